### hw/rtl/pmns_pkg.sv
// Shared constants, codes and types of the PMNS Montgomery multiplier.
package pmns_pkg;

   localparam int N      = 16;
   localparam int IDX_W  = $clog2(N);
   localparam int MAT_W  = $clog2(N * N);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(N - 1);

   localparam logic [2:0] REQ_LOAD_A  = 3'd0;
   localparam logic [2:0] REQ_LOAD_B  = 3'd1;
   localparam logic [2:0] REQ_LOAD_M  = 3'd2;
   localparam logic [2:0] REQ_LOAD_MP = 3'd3;
   localparam logic [2:0] REQ_START   = 3'd4;

   typedef enum logic {
      MODE_MAC,
      MODE_SCALE
   } mac_mode_type;

   typedef enum logic [1:0] {
      INIT_CLEAR,
      INIT_KEEP,
      INIT_LOAD
   } acc_init_type;

   typedef struct packed {
      logic         start;
      mac_mode_type mode;
      acc_init_type init;
   } mac_cmd_type;

   typedef enum logic [2:0] {
      E_IDLE,
      E_MUL,
      E_DRAIN,
      E_COR1,
      E_COR2
   } mac_state_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RD,
      S_GO,
      S_WAIT,
      S_SCALE,
      S_SWAIT,
      S_STORE,
      S_OUT_RD,
      S_OUT_LOAD,
      S_OUT_HOLD
   } seq_state_type;

   typedef enum logic [1:0] {
      PH_WRAP,
      PH_MAIN,
      PH_QUOT,
      PH_FOLD
   } phase_type;

endpackage

### hw/rtl/pmns_mac_unit.sv
// Multi-cycle 128x128 signed multiply-accumulate and 256-bit scale by lambda.
module pmns_mac_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  pmns_pkg::mac_cmd_type cmd,
   input  logic [127:0]         x_op,
   input  logic [127:0]         y_op,
   input  logic [255:0]         load_value,
   input  logic [15:0]          lambda,
   output logic                 busy,
   output logic [255:0]         acc
);

   pmns_pkg::mac_state_type state_ff, state_in;
   pmns_pkg::mac_mode_type  mode_ff;
   logic [127:0] x_ff, y_ff;
   logic [255:0] acc_ff, acc_in;
   logic [15:0]  lam_ff;
   logic [3:0]   cnt_ff;
   logic [63:0]  p_ff;
   logic [2:0]   pos_ff, pos;
   logic         pv_ff;
   logic [31:0]  mul_a, mul_b;
   logic         last_mul;
   logic [255:0] t_val, cor1, cor2, addend;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pmns_pkg::E_IDLE:  if (cmd.start) state_in = pmns_pkg::E_MUL;
         pmns_pkg::E_MUL:   if (last_mul) state_in = pmns_pkg::E_DRAIN;
         pmns_pkg::E_DRAIN: state_in = pmns_pkg::E_COR1;
         pmns_pkg::E_COR1:  state_in = pmns_pkg::E_COR2;
         pmns_pkg::E_COR2:  state_in = pmns_pkg::E_IDLE;
         default:           state_in = pmns_pkg::E_IDLE;
      endcase
   end

   always_comb begin
      t_val = {y_ff, x_ff};
      if (mode_ff == pmns_pkg::MODE_MAC) begin
         mul_a    = x_ff[32*cnt_ff[3:2] +: 32];
         mul_b    = y_ff[32*cnt_ff[1:0] +: 32];
         pos      = 3'({1'b0, cnt_ff[3:2]}) + 3'({1'b0, cnt_ff[1:0]});
         last_mul = (cnt_ff == 4'd15);
         cor1     = x_ff[127] ? {y_ff, 128'b0} : 256'b0;
         cor2     = y_ff[127] ? {x_ff, 128'b0} : 256'b0;
      end else begin
         mul_a    = t_val[32*cnt_ff[2:0] +: 32];
         mul_b    = {16'b0, lam_ff};
         pos      = cnt_ff[2:0];
         last_mul = (cnt_ff == 4'd7);
         cor1     = lam_ff[15] ? {t_val[239:0], 16'b0} : 256'b0;
         cor2     = 256'b0;
      end
      addend = pv_ff ? ({192'b0, p_ff} << {pos_ff, 5'b0}) : 256'b0;
      busy   = (state_ff != pmns_pkg::E_IDLE);
      acc    = acc_ff;
      case (state_ff)
         pmns_pkg::E_IDLE: begin
            case (cmd.init)
               pmns_pkg::INIT_CLEAR: acc_in = 256'b0;
               pmns_pkg::INIT_LOAD:  acc_in = load_value;
               default:              acc_in = acc_ff;
            endcase
            if (!cmd.start) acc_in = acc_ff;
         end
         pmns_pkg::E_MUL, pmns_pkg::E_DRAIN: acc_in = acc_ff + addend;
         pmns_pkg::E_COR1: acc_in = acc_ff - cor1;
         pmns_pkg::E_COR2: acc_in = acc_ff - cor2;
         default:          acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      p_ff   <= mul_a * mul_b;
      pos_ff <= pos;
      if (state_ff == pmns_pkg::E_IDLE && cmd.start) begin
         x_ff    <= x_op;
         y_ff    <= y_op;
         mode_ff <= cmd.mode;
         lam_ff  <= lambda;
         cnt_ff  <= 4'd0;
      end else if (state_ff == pmns_pkg::E_MUL) begin
         cnt_ff <= cnt_ff + 4'd1;
      end
      if (reset) begin
         state_ff <= pmns_pkg::E_IDLE;
         pv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         pv_ff    <= (state_ff == pmns_pkg::E_MUL);
      end
   end

endmodule

### hw/rtl/pmns_montgomery_multiplier_core.sv
// Top level of the PMNS Montgomery multiplier: operand stores, sequencer, result port.
// Loads of A, B, M and M' write the operand stores. A start runs 3*N^2 signed 128x128
// multiply-accumulates through one 32x32 multiplier (16 partial products each, each
// after a read of the operand stores), plus N lambda scalings, and then returns the
// coefficients of the result one at a time. No request is taken until the last
// coefficient of a result has been transferred.
module pmns_montgomery_multiplier_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_type,
   input  logic [3:0]         req_row,
   input  logic [3:0]         req_col,
   input  logic [63:0]        req_word_lo,
   input  logic signed [63:0] req_word_hi,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [3:0]         rsp_coef_index,
   output logic [63:0]        rsp_coef_lo,
   output logic signed [63:0] rsp_coef_hi,
   output logic               rsp_last,
   input  logic               csr_write_en,
   input  logic signed [15:0] csr_write_data
);

   localparam int IW = pmns_pkg::IDX_W;
   localparam int MW = pmns_pkg::MAT_W;

   pmns_pkg::seq_state_type state_ff, state_in;
   pmns_pkg::phase_type     ph_ff, ph_in;
   logic [IW-1:0] i_ff, i_in, j_ff, j_in;
   logic          nowrap_ff, nowrap_in;
   logic [15:0]   lambda_ff;

   logic [127:0] mem_a  [pmns_pkg::N];
   logic [127:0] mem_b  [pmns_pkg::N];
   logic [127:0] mem_m  [pmns_pkg::N * pmns_pkg::N];
   logic [127:0] mem_mp [pmns_pkg::N * pmns_pkg::N];
   logic [127:0] mem_v  [pmns_pkg::N];
   logic [255:0] mem_r  [pmns_pkg::N];

   logic [127:0] a_rd_ff, b_rd_ff, m_rd_ff, mp_rd_ff, v_rd_ff;
   logic [255:0] r_rd_ff;

   logic [IW-1:0] b_addr, r_addr;
   logic [IW:0]   wrap_idx;
   logic [MW-1:0] mat_addr, load_addr;
   logic          req_fire, row_ok, col_ok, r_we, v_we;

   pmns_pkg::mac_cmd_type cmd;
   logic [127:0] x_op, y_op;
   logic         busy;
   logic [255:0] acc;

   logic         rsp_valid_ff;
   logic [IW-1:0] rsp_index_ff;
   logic [127:0] rsp_coef_ff;
   logic         rsp_last_ff;

   pmns_mac_unit u_mac (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .x_op       (x_op),
      .y_op       (y_op),
      .load_value (r_rd_ff),
      .lambda     (lambda_ff),
      .busy       (busy),
      .acc        (acc)
   );

   // next state and loop counters
   always_comb begin
      state_in  = state_ff;
      ph_in     = ph_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      nowrap_in = nowrap_ff;
      case (state_ff)
         pmns_pkg::S_IDLE: begin
            if (req_fire && req_type == pmns_pkg::REQ_START) begin
               i_in      = '0;
               j_in      = IW'(1);
               ph_in     = pmns_pkg::PH_WRAP;
               nowrap_in = 1'b0;
               state_in  = pmns_pkg::S_RD;
            end
         end
         pmns_pkg::S_RD: state_in = pmns_pkg::S_GO;
         pmns_pkg::S_GO: state_in = pmns_pkg::S_WAIT;
         pmns_pkg::S_WAIT: begin
            if (!busy) begin
               case (ph_ff)
                  pmns_pkg::PH_WRAP: begin
                     if (j_ff == pmns_pkg::LAST_IDX) begin
                        state_in = pmns_pkg::S_SCALE;
                     end else begin
                        j_in     = j_ff + IW'(1);
                        state_in = pmns_pkg::S_RD;
                     end
                  end
                  pmns_pkg::PH_MAIN: begin
                     if (j_ff == i_ff) begin
                        state_in = pmns_pkg::S_STORE;
                     end else begin
                        j_in     = j_ff + IW'(1);
                        state_in = pmns_pkg::S_RD;
                     end
                  end
                  default: begin
                     if (j_ff == pmns_pkg::LAST_IDX) begin
                        state_in = pmns_pkg::S_STORE;
                     end else begin
                        j_in     = j_ff + IW'(1);
                        state_in = pmns_pkg::S_RD;
                     end
                  end
               endcase
            end
         end
         pmns_pkg::S_SCALE: state_in = pmns_pkg::S_SWAIT;
         pmns_pkg::S_SWAIT: begin
            if (!busy) begin
               ph_in    = pmns_pkg::PH_MAIN;
               j_in     = '0;
               state_in = pmns_pkg::S_RD;
            end
         end
         pmns_pkg::S_STORE: begin
            case (ph_ff)
               pmns_pkg::PH_MAIN: begin
                  if (i_ff == pmns_pkg::LAST_IDX) begin
                     ph_in    = pmns_pkg::PH_QUOT;
                     i_in     = '0;
                     j_in     = '0;
                     state_in = pmns_pkg::S_RD;
                  end else begin
                     i_in = i_ff + IW'(1);
                     j_in = i_ff + IW'(2);
                     if (i_ff + IW'(1) == pmns_pkg::LAST_IDX) begin
                        nowrap_in = 1'b1;
                        state_in  = pmns_pkg::S_SCALE;
                     end else begin
                        nowrap_in = 1'b0;
                        ph_in     = pmns_pkg::PH_WRAP;
                        state_in  = pmns_pkg::S_RD;
                     end
                  end
               end
               pmns_pkg::PH_QUOT: begin
                  j_in     = '0;
                  state_in = pmns_pkg::S_RD;
                  if (i_ff == pmns_pkg::LAST_IDX) begin
                     ph_in = pmns_pkg::PH_FOLD;
                     i_in  = '0;
                  end else begin
                     i_in = i_ff + IW'(1);
                  end
               end
               pmns_pkg::PH_FOLD: begin
                  if (i_ff == pmns_pkg::LAST_IDX) begin
                     i_in     = '0;
                     state_in = pmns_pkg::S_OUT_RD;
                  end else begin
                     i_in     = i_ff + IW'(1);
                     j_in     = '0;
                     state_in = pmns_pkg::S_RD;
                  end
               end
               default: state_in = pmns_pkg::S_IDLE;
            endcase
         end
         pmns_pkg::S_OUT_RD:   state_in = pmns_pkg::S_OUT_LOAD;
         pmns_pkg::S_OUT_LOAD: state_in = pmns_pkg::S_OUT_HOLD;
         pmns_pkg::S_OUT_HOLD: begin
            if (rsp_ready) begin
               if (i_ff == pmns_pkg::LAST_IDX) begin
                  state_in = pmns_pkg::S_IDLE;
               end else begin
                  i_in     = i_ff + IW'(1);
                  state_in = pmns_pkg::S_OUT_RD;
               end
            end
         end
         default: state_in = pmns_pkg::S_IDLE;
      endcase
   end

   // outputs: handshake, addresses, engine command, write enables
   always_comb begin
      req_ready = (state_ff == pmns_pkg::S_IDLE);
      req_fire  = req_valid && req_ready;
      row_ok    = (32'(req_row) < pmns_pkg::N);
      col_ok    = (32'(req_col) < pmns_pkg::N);
      load_addr = MW'(req_row[IW-1:0]) * MW'(pmns_pkg::N) + MW'(req_col[IW-1:0]);

      wrap_idx = {1'b0, i_ff} + (IW+1)'(pmns_pkg::N) - {1'b0, j_ff};
      b_addr   = (ph_ff == pmns_pkg::PH_WRAP) ? wrap_idx[IW-1:0] : (i_ff - j_ff);
      mat_addr = MW'(j_ff) * MW'(pmns_pkg::N) + MW'(i_ff);
      r_addr   = (ph_ff == pmns_pkg::PH_QUOT) ? j_ff : i_ff;

      cmd.start = (state_ff == pmns_pkg::S_GO) || (state_ff == pmns_pkg::S_SCALE);
      cmd.mode  = pmns_pkg::MODE_MAC;
      cmd.init  = pmns_pkg::INIT_KEEP;
      x_op      = a_rd_ff;
      y_op      = b_rd_ff;
      if (state_ff == pmns_pkg::S_SCALE) begin
         cmd.mode = pmns_pkg::MODE_SCALE;
         cmd.init = pmns_pkg::INIT_CLEAR;
         x_op     = nowrap_ff ? 128'b0 : acc[127:0];
         y_op     = nowrap_ff ? 128'b0 : acc[255:128];
      end else begin
         case (ph_ff)
            pmns_pkg::PH_WRAP: begin
               if ({1'b0, j_ff} == {1'b0, i_ff} + (IW+1)'(1)) cmd.init = pmns_pkg::INIT_CLEAR;
            end
            pmns_pkg::PH_QUOT: begin
               x_op = r_rd_ff[127:0];
               y_op = mp_rd_ff;
               if (j_ff == '0) cmd.init = pmns_pkg::INIT_CLEAR;
            end
            pmns_pkg::PH_FOLD: begin
               x_op = v_rd_ff;
               y_op = m_rd_ff;
               if (j_ff == '0) cmd.init = pmns_pkg::INIT_LOAD;
            end
            default: cmd.init = pmns_pkg::INIT_KEEP;
         endcase
      end

      r_we = (state_ff == pmns_pkg::S_STORE) &&
             (ph_ff == pmns_pkg::PH_MAIN || ph_ff == pmns_pkg::PH_FOLD);
      v_we = (state_ff == pmns_pkg::S_STORE) && (ph_ff == pmns_pkg::PH_QUOT);

      rsp_valid      = rsp_valid_ff;
      rsp_coef_index = 4'(rsp_index_ff);
      rsp_coef_lo    = rsp_coef_ff[63:0];
      rsp_coef_hi    = rsp_coef_ff[127:64];
      rsp_last       = rsp_last_ff;
   end

   always_ff @(posedge clock) begin
      a_rd_ff  <= mem_a[j_ff];
      b_rd_ff  <= mem_b[b_addr];
      m_rd_ff  <= mem_m[mat_addr];
      mp_rd_ff <= mem_mp[mat_addr];
      v_rd_ff  <= mem_v[j_ff];
      r_rd_ff  <= mem_r[r_addr];
      if (r_we) mem_r[i_ff] <= acc;
      if (v_we) mem_v[i_ff] <= acc[127:0];
      if (req_fire && row_ok) begin
         case (req_type)
            pmns_pkg::REQ_LOAD_A: mem_a[req_row[IW-1:0]] <= {req_word_hi, req_word_lo};
            pmns_pkg::REQ_LOAD_B: mem_b[req_row[IW-1:0]] <= {req_word_hi, req_word_lo};
            pmns_pkg::REQ_LOAD_M: begin
               if (col_ok) mem_m[load_addr] <= {req_word_hi, req_word_lo};
            end
            pmns_pkg::REQ_LOAD_MP: begin
               if (col_ok) mem_mp[load_addr] <= {req_word_hi, req_word_lo};
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in;
      j_ff <= j_in;
      if (state_ff == pmns_pkg::S_OUT_LOAD) begin
         rsp_index_ff <= i_ff;
         rsp_coef_ff  <= r_rd_ff[255:128];
         rsp_last_ff  <= (i_ff == pmns_pkg::LAST_IDX);
      end
      if (reset) begin
         state_ff     <= pmns_pkg::S_IDLE;
         ph_ff        <= pmns_pkg::PH_WRAP;
         nowrap_ff    <= 1'b0;
         lambda_ff    <= 16'd2;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ph_ff     <= ph_in;
         nowrap_ff <= nowrap_in;
         if (csr_write_en) lambda_ff <= csr_write_data;
         if (state_ff == pmns_pkg::S_OUT_LOAD) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule
